### hw/rtl/asrep_pkg.sv
// ----------------------------------------------------------------------------
// ASR envelope player package
// Shared widths, codes and beat types for the envelope table player.
// ----------------------------------------------------------------------------
package asrep_pkg;

  // Fixed field widths.
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEN_W        = 13;
  localparam int POS_W        = 13;
  localparam int LOAD_ADDR_W  = 12;
  localparam int CFG_DATA_W   = 13;

  // Width used for every compare against the memory depth; it holds the
  // largest depth and the sum of three full lengths.
  localparam int WIDE_W = 17;

  // Default memory depth.
  localparam int MEMORY_DEPTH_DEF = 4096;

  // Running extremes start at the far ends of the sample range.
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NEXT    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_SUSTAIN = 2'd1,
    REG_RELEASE = 2'd2,
    REG_LOOP    = 2'd3
  } cfg_reg_t;

  // Input beat.
  typedef struct packed {
    op_t                             operation;
    logic [LOAD_ADDR_W-1:0]          load_address;
    logic signed [SAMPLE_WIDTH-1:0]  load_value;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0]  sample_value;
    logic                            wrapped;
    logic                            released;
    logic signed [SAMPLE_WIDTH-1:0]  min_value;
    logic signed [SAMPLE_WIDTH-1:0]  max_value;
    logic                            config_error;
  } out_t;

endpackage

### hw/rtl/asrep_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module asrep_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/asrep_rem.sv
// ----------------------------------------------------------------------------
// Sustain offset remainder unit
// Restoring remainder, one quotient bit a cycle, for folding a position that
// lies past the sustain segment back into it.
// ----------------------------------------------------------------------------
module asrep_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [asrep_pkg::POS_W-1:0] dividend,
  input  logic [asrep_pkg::POS_W-1:0] divisor,
  input  logic                       take,
  output logic                       done,
  output logic [asrep_pkg::POS_W-1:0] remainder
);

  import asrep_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_RUN,
    RS_DONE
  } rem_state_t;

  rem_state_t       state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] dvd_r;
  logic [POS_W-1:0] dvs_r;
  logic [POS_W-1:0] rem_r;

  logic [POS_W:0]   trial;
  logic [POS_W:0]   diff;
  logic [POS_W-1:0] rem_nxt;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_r, dvd_r[POS_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[POS_W-1:0];
    end else begin
      rem_nxt = trial[POS_W-1:0];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        RS_IDLE: begin
          if (start) begin
            dvd_r   <= dividend;
            dvs_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= CNT_W'(POS_W);
            state_r <= RS_RUN;
          end
        end
        RS_RUN: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[POS_W-2:0], 1'b0};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= RS_DONE;
          end
        end
        RS_DONE: begin
          if (take) begin
            state_r <= RS_IDLE;
          end
        end
        default: begin
          state_r <= RS_IDLE;
        end
      endcase
    end
  end

  assign done      = (state_r == RS_DONE);
  assign remainder = rem_r;

endmodule

### hw/rtl/asr_envelope_table_player_core.sv
// ----------------------------------------------------------------------------
// ASR envelope table player
// Plays attack, looping sustain and release from one sample memory.
// ----------------------------------------------------------------------------
// A next beat's result passes the read stage and then the output register.
// Throughput: one beat a cycle, set by the single memory read port, when the
// output is not stalled. A position left past the sustain while looping (after
// a length change) runs the remainder unit first and holds off further beats.
// Reset (synchronous, rst_n low) resets position, release flag, extremes, valid
// flags and configuration (loop on); the sample memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module asr_envelope_table_player_core #(
  parameter int MEMORY_DEPTH = asrep_pkg::MEMORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  asrep_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output asrep_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  asrep_pkg::cfg_reg_t              cfg_index,
  input  logic [asrep_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import asrep_pkg::*;

  localparam int AW = $clog2(MEMORY_DEPTH);

  // Fields that travel with a sample while its read is in flight.
  typedef struct packed {
    logic                           wrapped;
    logic                           released;
    logic signed [SAMPLE_WIDTH-1:0] min_value;
    logic signed [SAMPLE_WIDTH-1:0] max_value;
    logic                           config_error;
  } side_t;

  // Configuration registers.
  logic [LEN_W-1:0] attack_r, sustain_r, release_r;
  logic             loop_r;

  // Player state.
  logic [POS_W-1:0]               pos_r;
  logic                           rel_r;
  logic signed [SAMPLE_WIDTH-1:0] min_r, max_r;

  // Read stage, output stage and the beat waiting for its remainder.
  logic  rd_valid_r, rd_zero_r;
  side_t rd_side_r;
  logic  out_valid_r;
  out_t  out_data_r;
  logic  pend_r;
  side_t pend_side_r;

  // Segment bounds.
  logic [LEN_W:0]   as_w;
  logic [LEN_W+1:0] total_w;
  logic             cfg_err_w;
  logic [WIDE_W-1:0] depth_w;

  assign as_w      = {1'b0, attack_r} + {1'b0, sustain_r};
  assign total_w   = {1'b0, as_w} + {2'b0, release_r};
  assign depth_w   = WIDE_W'(MEMORY_DEPTH);
  assign cfg_err_w = WIDE_W'(total_w) > depth_w;

  // Handshake.
  logic advance, acc, acc_load, acc_next;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = pend_r || (rd_valid_r && !advance);
  assign acc      = in_valid && !in_stall;
  assign acc_load = acc && (in_data.operation == OP_LOAD);
  assign acc_next = acc && (in_data.operation == OP_NEXT);

  // Play decision for a next beat: read address, zero sample, new flag and position.
  logic [POS_W-1:0] acc_addr;
  logic             acc_zero, acc_mod, rel_new, looping;
  logic [POS_W:0]   p1, np;
  logic [POS_W-1:0] pos_nxt;

  always_comb begin
    looping  = loop_r && !rel_r;
    rel_new  = rel_r;
    acc_mod  = 1'b0;
    acc_addr = pos_r;
    acc_zero = WIDE_W'(pos_r) >= depth_w;
    if ({1'b0, pos_r} < {1'b0, attack_r}) begin
      acc_addr = pos_r;
    end else if (({1'b0, pos_r} < as_w) || (looping && (sustain_r != '0))) begin
      acc_mod = !({1'b0, pos_r} < as_w);
    end else if (looping) begin
      // Empty looping sustain holds the last attack sample.
      acc_addr = attack_r - LEN_W'(1);
      if (attack_r != '0) begin
        acc_zero = WIDE_W'(acc_addr) >= depth_w;
      end else begin
        acc_zero = 1'b1;
      end
    end else begin
      rel_new  = 1'b1;
      acc_zero = acc_zero || !({2'b0, pos_r} < total_w);
    end

    p1 = {1'b0, pos_r} + (POS_W+1)'(1);
    if ((p1 >= as_w) && loop_r && !rel_new) begin
      np = {1'b0, attack_r};
    end else if ({1'b0, p1} >= total_w) begin
      np = '0;
    end else begin
      np = p1;
    end
    pos_nxt = np[POS_W-1:0];
  end

  // Remainder unit for a position past the looping sustain.
  logic             rem_done;
  logic [POS_W-1:0] rem_q;
  logic             issue_mod, issue_acc, issue;

  asrep_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (acc_next && acc_mod),
    .dividend  (pos_r - attack_r),
    .divisor   (sustain_r),
    .take      (issue_mod),
    .done      (rem_done),
    .remainder (rem_q)
  );

  logic [POS_W:0] mod_addr;
  logic           mod_zero;

  assign mod_addr  = {1'b0, attack_r} + {1'b0, rem_q};
  assign mod_zero  = WIDE_W'(mod_addr) >= depth_w;
  assign issue_mod = pend_r && rem_done && (!rd_valid_r || advance);
  assign issue_acc = acc_next && !acc_mod;
  assign issue     = issue_acc || issue_mod;

  // Sample memory.
  logic [WIDE_W-1:0]       rd_wide, ld_wide;
  logic                    rd_zero_nxt, ld_ok;
  logic [SAMPLE_WIDTH-1:0] ram_q;

  assign rd_wide     = issue_mod ? WIDE_W'(mod_addr) : WIDE_W'(acc_addr);
  assign rd_zero_nxt = issue_mod ? mod_zero : acc_zero;
  assign ld_wide     = WIDE_W'(in_data.load_address);
  assign ld_ok       = ld_wide < depth_w;

  asrep_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MEMORY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (acc_load && ld_ok),
    .waddr (ld_wide[AW-1:0]),
    .wdata (in_data.load_value),
    .re    (issue && !rd_zero_nxt),
    .raddr (rd_wide[AW-1:0]),
    .rdata (ram_q)
  );

  // Side fields of a next beat as seen once it is taken.
  side_t acc_side;

  always_comb begin
    acc_side.wrapped      = (pos_nxt == '0);
    acc_side.released     = rel_new;
    acc_side.min_value    = min_r;
    acc_side.max_value    = max_r;
    acc_side.config_error = cfg_err_w;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      sustain_r <= '0;
      release_r <= '0;
      loop_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_wdata[LEN_W-1:0];
        REG_SUSTAIN: sustain_r <= cfg_wdata[LEN_W-1:0];
        REG_RELEASE: release_r <= cfg_wdata[LEN_W-1:0];
        REG_LOOP:    loop_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Position, release flag and running extremes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rel_r <= 1'b0;
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
    end else if (acc) begin
      unique case (in_data.operation)
        OP_LOAD: begin
          if (ld_ok) begin
            if (in_data.load_value < min_r) begin
              min_r <= in_data.load_value;
            end
            if (in_data.load_value > max_r) begin
              max_r <= in_data.load_value;
            end
          end
        end
        OP_NEXT: begin
          pos_r <= pos_nxt;
          rel_r <= rel_new;
        end
        OP_RELEASE: begin
          rel_r <= 1'b1;
        end
        OP_RESTART: begin
          pos_r <= '0;
          rel_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Read stage and the beat parked on the remainder unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid_r <= 1'b1;
      end else if (advance) begin
        rd_valid_r <= 1'b0;
      end
      if (acc_next && acc_mod) begin
        pend_r <= 1'b1;
      end else if (issue_mod) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_acc) begin
      rd_side_r <= acc_side;
    end else if (issue_mod) begin
      rd_side_r <= pend_side_r;
    end
    if (issue) begin
      rd_zero_r <= rd_zero_nxt;
    end
    if (acc_next && acc_mod) begin
      pend_side_r <= acc_side;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rd_valid_r) begin
      out_data_r.sample_value <= rd_zero_r ? '0 : ram_q;
      out_data_r.wrapped      <= rd_side_r.wrapped;
      out_data_r.released     <= rd_side_r.released;
      out_data_r.min_value    <= rd_side_r.min_value;
      out_data_r.max_value    <= rd_side_r.max_value;
      out_data_r.config_error <= rd_side_r.config_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
